>>> rtl/strongly_connected_component_grouper_defines.svh
// Assertion macros shared by the grouper RTL.
`ifndef STRONGLY_CONNECTED_COMPONENT_GROUPER_DEFINES_SVH
`define STRONGLY_CONNECTED_COMPONENT_GROUPER_DEFINES_SVH

// Property that holds at every clock edge out of reset.
`define SCC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("scc assertion failed");

// Same-cycle implication.
`define SCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scc assertion failed");

`endif

>>> rtl/scc_pkg.sv
// Shared constants of the strongly connected component grouper.
package scc_pkg;

  localparam int unsigned ID_W  = 8;
  localparam int unsigned IDX_W = 6;

  localparam int unsigned MAX_REACTIONS_DEF = 64;
  localparam int unsigned NODE_ID_RANGE_DEF = 256;
  localparam int unsigned MAX_NODES_DEF     = 128;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

endpackage

>>> rtl/scc_if.sv
// Request channel interfaces of the grouper.
interface scc_in_if import scc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            op;
  logic [ID_W-1:0] product_node;
  logic [ID_W-1:0] substrate_node;
  logic            single_substrate;

  modport source (output valid, op, product_node, substrate_node, single_substrate,
                  input ready);
  modport sink   (input valid, op, product_node, substrate_node, single_substrate,
                  output ready);
endinterface

interface scc_out_if import scc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] reaction_index;
  logic [IDX_W-1:0] component_index;
  logic             last_in_component;
  logic             last_overall;
  logic             overflow;

  modport source (output valid, reaction_index, component_index, last_in_component,
                  last_overall, overflow, input ready);
  modport sink   (input valid, reaction_index, component_index, last_in_component,
                  last_overall, overflow, output ready);
endinterface

>>> rtl/strongly_connected_component_grouper.sv
// Strongly connected component grouper: loads reactions, then groups them by SCC.
//
// A load request (op = load) stores one reaction and ranks its nodes by first
// appearance (single substrate first, then product); a new product rank is
// written in a further step, and a full store only sets the overflow flag.
// A run request performs Kosaraju's two depth-first passes with an
// explicit stack memory, then emits every stored reaction grouped by
// component (discovery order, load order inside a component), and clears the
// store. Every step of the run is one read of the reaction store: each pass
// scans all reactions once for every node, each second-pass walk (one per
// component, emitted or not) adds one emit scan over all reactions, and
// root checks and stack pops come on top; output back pressure stretches
// the emit scans. in_i.ready is high only while idle.
module strongly_connected_component_grouper import scc_pkg::*; #(
  parameter int unsigned MAX_REACTIONS = MAX_REACTIONS_DEF,
  parameter int unsigned NODE_ID_RANGE = NODE_ID_RANGE_DEF,
  parameter int unsigned MAX_NODES     = MAX_NODES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scc_in_if.sink     in_i,
  scc_out_if.source  out_o
);
  `include "strongly_connected_component_grouper_defines.svh"

  localparam int unsigned AW   = $clog2(MAX_REACTIONS);     // reaction address
  localparam int unsigned CW   = AW + 1;                     // reaction count
  localparam int unsigned RW   = $clog2(MAX_NODES);          // node rank
  localparam int unsigned NCW  = RW + 1;                     // node count / sp
  localparam int unsigned NDEP = (NODE_ID_RANGE < 256) ? NODE_ID_RANGE : 256;
  localparam int unsigned NW   = $clog2(NDEP);               // folded node id
  localparam int unsigned RSW  = 2 * RW + 1;                 // {single, sub, prod}
  localparam int unsigned STW  = RW + CW;                    // {node, next index}

  // Node ids folded into the id range; built at elaboration.
  typedef logic [NW-1:0] id_map_t [256];
  function automatic id_map_t build_id_map();
    id_map_t m;
    for (int k = 0; k < 256; k++) begin
      m[k] = NW'(k % NODE_ID_RANGE);
    end
    return m;
  endfunction
  localparam id_map_t ID_MAP = build_id_map();

  typedef enum logic [3:0] {
    ST_IDLE, ST_LD_WR, ST_LD_PROD,
    ST_P1_ROOT, ST_P1_SCAN, ST_P1_POPW,
    ST_P2_NEXT, ST_P2_POP, ST_P2_SCAN,
    ST_EM_SCAN, ST_EM_FIN
  } state_e;

  // Memories
  logic [RSW-1:0] rs_mem  [MAX_REACTIONS];
  logic [RW-1:0]  rk_mem  [NDEP];
  logic [RW-1:0]  fin_mem [MAX_NODES];
  logic [STW-1:0] stk_mem [MAX_NODES];

  state_e            state_q, state_d;
  logic [NDEP-1:0]   rk_valid_q, rk_valid_d;
  logic [MAX_NODES-1:0] vis_q, vis_d, mem_q, mem_d;
  logic [CW-1:0]     rcount_q, rcount_d, ridx_q, ridx_d;
  logic [NCW-1:0]    ncount_q, ncount_d, sp_q, sp_d, fc_q, fc_d, s_q, s_d;
  logic              ovf_q, ovf_d;
  logic [IDX_W-1:0]  comp_q, comp_d;
  logic              found_q, found_d;
  logic              pend_valid_q, pend_valid_d;
  logic              ovalid_q, ovalid_d;

  // payload registers
  logic [NW-1:0]     ld_sub_q, ld_sub_d, ld_prod_q, ld_prod_d;
  logic              ld_single_q, ld_single_d;
  logic [RW-1:0]     pr_q, pr_d;
  logic [RW-1:0]     top_v_q, top_v_d;
  logic [AW-1:0]     pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0]  pend_comp_q, pend_comp_d;
  logic              pend_lic_q, pend_lic_d;
  logic [IDX_W-1:0]  o_idx_q, o_idx_d, o_comp_q, o_comp_d;
  logic              o_lic_q, o_lic_d, o_lo_q, o_lo_d, o_ovf_q, o_ovf_d;

  // read data
  logic [RSW-1:0]    rs_rd_q;
  logic [RW-1:0]     rk_sub_q, rk_prod_q, fin_rd_q;
  logic [STW-1:0]    stk_rd_q;

  // memory write ports
  logic              rs_we, rk_we, fin_we, stk_we;
  logic [AW-1:0]     rs_wa;
  logic [RSW-1:0]    rs_wd;
  logic [NW-1:0]     rk_wa;
  logic [RW-1:0]     rk_wd, fin_wd;
  logic [RW-1:0]     fin_wa, stk_wa, stk_ra, fin_ra;
  logic [STW-1:0]    stk_wd;

  // decoded fields
  logic              rd_single;
  logic [RW-1:0]     rd_sub, rd_prod;
  logic              out_free;
  logic [NW-1:0]     in_sub_id, in_prod_id;

  // load decode
  logic              sub_new, prod_new, same_node;
  logic [NCW:0]      need_tot;
  logic [RW-1:0]     sub_rank, prod_rank;

  assign rd_single = rs_rd_q[RSW-1];
  assign rd_sub    = rs_rd_q[2*RW-1:RW];
  assign rd_prod   = rs_rd_q[RW-1:0];
  assign out_free  = !ovalid_q || out_o.ready;
  assign in_sub_id = ID_MAP[in_i.substrate_node];
  assign in_prod_id = ID_MAP[in_i.product_node];

  assign in_i.ready             = (state_q == ST_IDLE);
  assign out_o.valid            = ovalid_q;
  assign out_o.reaction_index   = o_idx_q;
  assign out_o.component_index  = o_comp_q;
  assign out_o.last_in_component = o_lic_q;
  assign out_o.last_overall     = o_lo_q;
  assign out_o.overflow         = o_ovf_q;

  // Load bookkeeping, valid in ST_LD_WR.
  always_comb begin
    same_node = ld_single_q && (ld_sub_q == ld_prod_q);
    sub_new   = ld_single_q && !rk_valid_q[ld_sub_q];
    prod_new  = !rk_valid_q[ld_prod_q] && !same_node;
    need_tot  = {1'b0, ncount_q} + (NCW+1)'(sub_new) + (NCW+1)'(prod_new);
    sub_rank  = rk_valid_q[ld_sub_q] ? rk_sub_q : ncount_q[RW-1:0];
    if (rk_valid_q[ld_prod_q]) begin
      prod_rank = rk_prod_q;
    end else if (same_node) begin
      prod_rank = sub_rank;
    end else begin
      prod_rank = ncount_q[RW-1:0] + RW'(sub_new);
    end
  end

  always_comb begin
    state_d      = state_q;
    rk_valid_d   = rk_valid_q;
    vis_d        = vis_q;
    mem_d        = mem_q;
    rcount_d     = rcount_q;
    ridx_d       = ridx_q;
    ncount_d     = ncount_q;
    sp_d         = sp_q;
    fc_d         = fc_q;
    s_d          = s_q;
    ovf_d        = ovf_q;
    comp_d       = comp_q;
    found_d      = found_q;
    pend_valid_d = pend_valid_q;
    ovalid_d     = ovalid_q && !out_o.ready;
    ld_sub_d     = ld_sub_q;
    ld_prod_d    = ld_prod_q;
    ld_single_d  = ld_single_q;
    pr_d         = pr_q;
    top_v_d      = top_v_q;
    pend_idx_d   = pend_idx_q;
    pend_comp_d  = pend_comp_q;
    pend_lic_d   = pend_lic_q;
    o_idx_d      = o_idx_q;
    o_comp_d     = o_comp_q;
    o_lic_d      = o_lic_q;
    o_lo_d       = o_lo_q;
    o_ovf_d      = o_ovf_q;
    rs_we = 1'b0; rs_wa = rcount_q[AW-1:0]; rs_wd = {ld_single_q, sub_rank, prod_rank};
    rk_we = 1'b0; rk_wa = ld_sub_q;         rk_wd = sub_rank;
    fin_we = 1'b0; fin_wa = fc_q[RW-1:0];   fin_wd = top_v_q;
    stk_we = 1'b0; stk_wa = sp_q[RW-1:0];   stk_wd = {top_v_q, ridx_q};

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.op == OP_RUN) begin
            vis_d   = '0;
            s_d     = '0;
            fc_d    = '0;
            sp_d    = '0;
            comp_d  = '0;
            state_d = ST_P1_ROOT;
          end else if (rcount_q >= CW'(MAX_REACTIONS)) begin
            ovf_d = 1'b1;
          end else begin
            ld_sub_d    = in_i.single_substrate ? in_sub_id : '0;
            ld_prod_d   = in_prod_id;
            ld_single_d = in_i.single_substrate;
            state_d     = ST_LD_WR;
          end
        end
      end

      ST_LD_WR: begin
        if (need_tot > (NCW+1)'(MAX_NODES)) begin
          ovf_d   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rs_we    = 1'b1;
          rcount_d = rcount_q + 1'b1;
          ncount_d = need_tot[NCW-1:0];
          pr_d     = prod_rank;
          if (sub_new) begin
            rk_we = 1'b1;
            rk_valid_d[ld_sub_q] = 1'b1;
          end
          state_d = prod_new ? ST_LD_PROD : ST_IDLE;
        end
      end

      ST_LD_PROD: begin
        rk_we = 1'b1;
        rk_wa = ld_prod_q;
        rk_wd = pr_q;
        rk_valid_d[ld_prod_q] = 1'b1;
        state_d = ST_IDLE;
      end

      // Pass 1: forward walk, records finish order.
      ST_P1_ROOT: begin
        if (s_q >= ncount_q) begin
          vis_d   = '0;
          s_d     = '0;
          state_d = ST_P2_NEXT;
        end else if (vis_q[s_q[RW-1:0]]) begin
          s_d = s_q + 1'b1;
        end else begin
          vis_d[s_q[RW-1:0]] = 1'b1;
          top_v_d = s_q[RW-1:0];
          sp_d    = NCW'(1);
          ridx_d  = '0;
          state_d = ST_P1_SCAN;
        end
      end

      ST_P1_SCAN: begin
        if (ridx_q >= rcount_q) begin
          if (fc_q < NCW'(MAX_NODES)) begin
            fin_we = 1'b1;
            fc_d   = fc_q + 1'b1;
          end
          sp_d = sp_q - 1'b1;
          if (sp_q == NCW'(1)) begin
            s_d     = s_q + 1'b1;
            state_d = ST_P1_ROOT;
          end else begin
            state_d = ST_P1_POPW;
          end
        end else if (rd_single && rd_sub == top_v_q && !vis_q[rd_prod] &&
                     sp_q < NCW'(MAX_NODES)) begin
          stk_we  = 1'b1;
          stk_wa  = RW'(sp_q - 1'b1);
          stk_wd  = {top_v_q, ridx_q + 1'b1};
          vis_d[rd_prod] = 1'b1;
          top_v_d = rd_prod;
          sp_d    = sp_q + 1'b1;
          ridx_d  = '0;
        end else begin
          ridx_d = ridx_q + 1'b1;
        end
      end

      ST_P1_POPW: begin
        top_v_d = stk_rd_q[STW-1:CW];
        ridx_d  = stk_rd_q[CW-1:0];
        state_d = ST_P1_SCAN;
      end

      // Pass 2: reverse walk from each root in reverse finish order.
      ST_P2_NEXT: begin
        if (s_q >= fc_q) begin
          state_d = ST_EM_FIN;
        end else begin
          s_d = s_q + 1'b1;
          if (!vis_q[fin_rd_q]) begin
            mem_d = '0;
            mem_d[fin_rd_q] = 1'b1;
            vis_d[fin_rd_q] = 1'b1;
            stk_we  = 1'b1;
            stk_wa  = '0;
            stk_wd  = {fin_rd_q, CW'(0)};
            sp_d    = NCW'(1);
            state_d = ST_P2_POP;
          end
        end
      end

      ST_P2_POP: begin
        ridx_d = '0;
        if (sp_q == '0) begin
          found_d = 1'b0;
          state_d = ST_EM_SCAN;
        end else begin
          top_v_d = stk_rd_q[STW-1:CW];
          sp_d    = sp_q - 1'b1;
          state_d = ST_P2_SCAN;
        end
      end

      ST_P2_SCAN: begin
        if (ridx_q >= rcount_q) begin
          state_d = ST_P2_POP;
        end else begin
          ridx_d = ridx_q + 1'b1;
          if (rd_single && rd_prod == top_v_q && !vis_q[rd_sub] &&
              sp_q < NCW'(MAX_NODES)) begin
            vis_d[rd_sub] = 1'b1;
            mem_d[rd_sub] = 1'b1;
            stk_we = 1'b1;
            stk_wd = {rd_sub, CW'(0)};
            sp_d   = sp_q + 1'b1;
          end
        end
      end

      // Emit members in load order; one result held back to mark the last.
      ST_EM_SCAN: begin
        if (ridx_q >= rcount_q) begin
          if (found_q) begin
            pend_lic_d = 1'b1;
            comp_d     = comp_q + 1'b1;
          end
          state_d = ST_P2_NEXT;
        end else if (!mem_q[rd_prod]) begin
          ridx_d = ridx_q + 1'b1;
        end else if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            ovalid_d = 1'b1;
            o_idx_d  = IDX_W'(pend_idx_q);
            o_comp_d = pend_comp_q;
            o_lic_d  = pend_lic_q;
            o_lo_d   = 1'b0;
            o_ovf_d  = ovf_q;
          end
          pend_valid_d = 1'b1;
          pend_idx_d   = ridx_q[AW-1:0];
          pend_comp_d  = comp_q;
          pend_lic_d   = 1'b0;
          found_d      = 1'b1;
          ridx_d       = ridx_q + 1'b1;
        end
      end

      ST_EM_FIN: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            ovalid_d = 1'b1;
            o_idx_d  = IDX_W'(pend_idx_q);
            o_comp_d = pend_comp_q;
            o_lic_d  = pend_lic_q;
            o_lo_d   = 1'b1;
            o_ovf_d  = ovf_q;
          end
          pend_valid_d = 1'b0;
          rcount_d     = '0;
          ncount_d     = '0;
          ovf_d        = 1'b0;
          rk_valid_d   = '0;
          vis_d        = '0;
          mem_d        = '0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Read addresses follow the next index so data lines up with the index register.
  assign stk_ra = RW'(sp_d - 1'b1);
  assign fin_ra = RW'(fc_d - 1'b1 - s_d);

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    if (rk_we) rk_mem[rk_wa] <= rk_wd;
    if (fin_we) fin_mem[fin_wa] <= fin_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    rs_rd_q  <= rs_mem[ridx_d[AW-1:0]];
    fin_rd_q <= fin_mem[fin_ra];
    stk_rd_q <= (stk_we && stk_wa == stk_ra) ? stk_wd : stk_mem[stk_ra];
    if (state_q == ST_IDLE) begin
      rk_sub_q  <= rk_mem[in_sub_id];
      rk_prod_q <= rk_mem[in_prod_id];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rk_valid_q   <= '0;
      vis_q        <= '0;
      mem_q        <= '0;
      rcount_q     <= '0;
      ridx_q       <= '0;
      ncount_q     <= '0;
      sp_q         <= '0;
      fc_q         <= '0;
      s_q          <= '0;
      ovf_q        <= 1'b0;
      comp_q       <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      rk_valid_q   <= rk_valid_d;
      vis_q        <= vis_d;
      mem_q        <= mem_d;
      rcount_q     <= rcount_d;
      ridx_q       <= ridx_d;
      ncount_q     <= ncount_d;
      sp_q         <= sp_d;
      fc_q         <= fc_d;
      s_q          <= s_d;
      ovf_q        <= ovf_d;
      comp_q       <= comp_d;
      found_q      <= found_d;
      pend_valid_q <= pend_valid_d;
      ovalid_q     <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_sub_q    <= ld_sub_d;
    ld_prod_q   <= ld_prod_d;
    ld_single_q <= ld_single_d;
    pr_q        <= pr_d;
    top_v_q     <= top_v_d;
    pend_idx_q  <= pend_idx_d;
    pend_comp_q <= pend_comp_d;
    pend_lic_q  <= pend_lic_d;
    o_idx_q     <= o_idx_d;
    o_comp_q    <= o_comp_d;
    o_lic_q     <= o_lic_d;
    o_lo_q      <= o_lo_d;
    o_ovf_q     <= o_ovf_d;
  end

  `SCC_ASSERT_ALWAYS(a_node_bound, ncount_q <= NCW'(MAX_NODES))
  `SCC_ASSERT_ALWAYS(a_stack_bound, sp_q <= NCW'(MAX_NODES))
  `SCC_ASSERT_IMP(a_idle_no_pend, state_q == ST_IDLE, !pend_valid_q)
  `SCC_ASSERT_IMP(a_last_closes_comp, ovalid_q && o_lo_q, o_lic_q)

endmodule
